// ===== rtl/websocket_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define WSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WSD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSD_ASSERT(lbl, clk, rstn, prop, msg)
`define WSD_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parser states, header constants and the parsed-item record.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    ST_FLAGS = 3'd0,
    ST_LEN   = 3'd1,
    ST_EXT   = 3'd2,
    ST_KEY   = 3'd3,
    ST_DATA  = 3'd4
  } wsd_state_e;

  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [7:0] flags;
    logic       last;
    logic       empty;
  } wsd_entry_t;

endpackage

// ===== rtl/wsd_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Receive byte channel and deframed result channel.
// ----------------------------------------------------------------------------
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] frame_flags;
  logic       last_of_frame;
  logic       empty_frame;

  modport source (output valid, output payload_byte, output frame_flags,
                  output last_of_frame, output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_flags,
                  input last_of_frame, input empty_frame, output ready);
endinterface

// ===== rtl/wsd_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Accepts stream bytes, tracks the frame header and classifies payload bytes.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsd_front
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       push_o,
  input  logic       push_ready_i,
  output wsd_entry_t push_entry_o
);

  wsd_state_e  state_q, state_d;
  logic [7:0]  flags_q;
  logic [63:0] remain_q;
  logic [3:0]  ext_left_q;
  logic        masked_q;
  logic [31:0] key_q;
  logic [2:0]  key_left_q;
  logic [1:0]  pos_q;

  logic        acc;
  logic [6:0]  len_code;
  logic        len_is_ext;
  logic [63:0] len_ext;
  logic        ext_done;
  logic        key_done;
  logic        data_last;
  logic [7:0]  key_sel;

  assign in_ready_o = push_ready_i;
  assign acc        = in_valid_i && push_ready_i;
  assign len_code   = in_byte_i[6:0];
  assign len_is_ext = (len_code == LEN_CODE_16) || (len_code == LEN_CODE_64);
  assign len_ext    = {remain_q[55:0], in_byte_i};
  assign ext_done   = (ext_left_q <= 4'd1);
  assign key_done   = (key_left_q <= 3'd1);
  assign data_last  = (remain_q == 64'd1);

  always_comb begin
    case (pos_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (acc) begin
      unique case (state_q)
        ST_FLAGS: state_d = ST_LEN;
        ST_LEN: begin
          if (len_is_ext) state_d = ST_EXT;
          else if (in_byte_i[7]) state_d = ST_KEY;
          else if (len_code == 7'd0) state_d = ST_FLAGS;
          else state_d = ST_DATA;
        end
        ST_EXT: begin
          if (ext_done) begin
            if (masked_q) state_d = ST_KEY;
            else if (len_ext == 64'd0) state_d = ST_FLAGS;
            else state_d = ST_DATA;
          end
        end
        ST_KEY: begin
          if (key_done) state_d = (remain_q == 64'd0) ? ST_FLAGS : ST_DATA;
        end
        ST_DATA: begin
          if (data_last) state_d = ST_FLAGS;
        end
        default: state_d = ST_LEN;
      endcase
    end
  end

  always_comb begin
    push_o             = 1'b0;
    push_entry_o       = '0;
    push_entry_o.flags = flags_q;
    unique case (state_q)
      ST_LEN: begin
        if (acc && !len_is_ext && !in_byte_i[7] && len_code == 7'd0) begin
          push_o             = 1'b1;
          push_entry_o.last  = 1'b1;
          push_entry_o.empty = 1'b1;
        end
      end
      ST_EXT: begin
        if (acc && ext_done && !masked_q && len_ext == 64'd0) begin
          push_o             = 1'b1;
          push_entry_o.last  = 1'b1;
          push_entry_o.empty = 1'b1;
        end
      end
      ST_KEY: begin
        if (acc && key_done && remain_q == 64'd0) begin
          push_o             = 1'b1;
          push_entry_o.last  = 1'b1;
          push_entry_o.empty = 1'b1;
        end
      end
      ST_DATA: begin
        push_o            = acc;
        push_entry_o.data = in_byte_i;
        push_entry_o.key  = masked_q ? key_sel : 8'd0;
        push_entry_o.last = data_last;
      end
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FLAGS;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      remain_q   <= '0;
      ext_left_q <= '0;
      masked_q   <= 1'b0;
      key_q      <= '0;
      key_left_q <= '0;
      pos_q      <= '0;
    end else if (acc) begin
      case (state_q)
        ST_LEN: begin
          masked_q   <= in_byte_i[7];
          remain_q   <= len_is_ext ? 64'd0 : {57'd0, len_code};
          ext_left_q <= (len_code == LEN_CODE_64) ? EXT_BYTES_64 : EXT_BYTES_16;
          key_q      <= '0;
          key_left_q <= KEY_BYTES;
          pos_q      <= '0;
        end
        ST_EXT: begin
          remain_q   <= len_ext;
          ext_left_q <= ext_left_q - 4'd1;
        end
        ST_KEY: begin
          key_q      <= {key_q[23:0], in_byte_i};
          key_left_q <= key_left_q - 3'd1;
        end
        ST_DATA: begin
          remain_q <= remain_q - 64'd1;
          pos_q    <= pos_q + 2'd1;
        end
        default: flags_q <= in_byte_i;
      endcase
    end
  end

  `WSD_ASSERT(a_empty_is_last, clk_i, rst_ni, push_o && push_entry_o.empty |-> push_entry_o.last && push_entry_o.data == 8'd0, "empty frame result must be last and carry zero")
  `WSD_ASSERT_NR(a_data_len_nonzero, clk_i, state_q == ST_DATA |-> remain_q != 64'd0, "payload phase with no bytes left")
  `WSD_ASSERT(a_last_ends_frame, clk_i, rst_ni, push_o && push_entry_o.last |=> state_q == ST_FLAGS, "frame end must return to header start")

endmodule

// ===== rtl/wsd_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer item queue
// Short FIFO between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_queue
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       push_ready_o,
  input  wsd_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output wsd_entry_t pop_entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wsd_entry_t       store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = store_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/wsd_back.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Unmasks queued payload bytes into the result register.
// ----------------------------------------------------------------------------
module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  wsd_entry_t pop_entry_i,
  wsd_tx_if.source   tx_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic [7:0] flags_q;
  logic       last_q;
  logic       empty_q;
  logic       take;

  assign take        = !valid_q || tx_o.ready;
  assign pop_ready_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pop_valid_i) begin
      byte_q  <= pop_entry_i.data ^ pop_entry_i.key;
      flags_q <= pop_entry_i.flags;
      last_q  <= pop_entry_i.last;
      empty_q <= pop_entry_i.empty;
    end
  end

  assign tx_o.valid         = valid_q;
  assign tx_o.payload_byte  = byte_q;
  assign tx_o.frame_flags   = flags_q;
  assign tx_o.last_of_frame = last_q;
  assign tx_o.empty_frame   = empty_q;

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Path: a payload byte, or the empty-frame mark, passes from the parser into the
//   parser-to-output queue and then into the output register before it is valid.
// Throughput: one received byte per cycle while the queue has room; only an empty frame's header gives a result.
//   Input ready follows the free space of the parser-to-output queue.
// Reset: asynchronous; parser returns to the frame start, queue and output
//   register empty. No clearing pass.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers and emits unmasked payload bytes with frame flags.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wsd_rx_if.sink   rx_i,
  wsd_tx_if.source tx_o
);

  logic       push;
  logic       push_ready;
  wsd_entry_t push_entry;
  logic       pop_valid;
  logic       pop_ready;
  wsd_entry_t pop_entry;

  wsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rx_i.valid),
    .in_ready_o   (rx_i.ready),
    .in_byte_i    (rx_i.rx_byte),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .tx_o        (tx_o)
  );

endmodule
